// ===== rtl/ecmf_pkg.sv =====
// shared constants and types for the edge-clipped median filter
package ecmf_pkg;
  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned MaxWindow = 7;
  localparam int unsigned MaxRadius = MaxWindow / 2;
  localparam int unsigned MaxTaps   = MaxWindow * MaxWindow;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);
  localparam int unsigned AddrW     = ColW + RowW;
  localparam int unsigned TapW      = $clog2(MaxTaps + 1);

  // configuration register indexes
  localparam logic [1:0] RegWindowSize  = 2'd0;
  localparam logic [1:0] RegImageWidth  = 2'd1;
  localparam logic [1:0] RegImageHeight = 2'd2;

  // operation codes
  localparam logic OpLoad   = 1'b0;
  localparam logic OpFilter = 1'b1;

  typedef logic [23:0] pixel_t;

  // control from the window sequencer to the rank selector
  typedef struct packed {
    logic           clear;
    logic           push;
    logic           done;
    logic [TapW-1:0] count;
  } sel_ctrl_t;
endpackage

// ===== rtl/ecmf_rank_sel.sv =====
// per-channel rank selection over collected window samples, one sample compared per cycle
module ecmf_rank_sel
  import ecmf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sel_ctrl_t   ctrl_i,
  input  logic [7:0]  sample_i,
  output logic        valid_o,
  output logic [7:0]  median_o
);
  typedef enum logic [3:0] {
    S_COLLECT = 4'b0001,
    S_SCAN    = 4'b0010,
    S_LAST    = 4'b0100,
    S_OUT     = 4'b1000
  } sel_state_e;

  sel_state_e       state_q, state_d;
  logic [7:0]       buf_q [MaxTaps];
  logic [TapW-1:0]  wr_q, wr_d;
  logic [TapW-1:0]  n_q, n_d;
  logic [TapW-1:0]  i_q, i_d;
  logic [TapW-1:0]  j_q, j_d;
  logic [TapW-1:0]  less_q, less_d;
  logic [TapW-1:0]  eq_q, eq_d;
  logic [7:0]       lo_q, lo_d, hi_q, hi_d;
  logic             got_lo_q, got_lo_d, got_hi_q, got_hi_d;
  logic [7:0]       cand_q, other_q;
  logic             rd_v_q, rd_v_d, rd_last_q, rd_last_d;
  logic [TapW-1:0]  k_lo, k_hi;
  logic [TapW:0]    less_n, eq_n;
  logic [8:0]       avg;

  assign k_lo  = TapW'((n_q - TapW'(1)) >> 1);
  assign k_hi  = TapW'(n_q >> 1);
  assign less_n = {1'b0, less_q} + {{TapW{1'b0}}, other_q < cand_q};
  assign eq_n   = {1'b0, eq_q} + {{TapW{1'b0}}, other_q == cand_q};
  assign avg    = ({1'b0, lo_q} + {1'b0, hi_q}) >> 1;

  // sample buffer, registered reads of the candidate and the compared sample
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      buf_q[wr_q] <= sample_i;
    end
    cand_q  <= buf_q[i_q];
    other_q <= buf_q[j_q];
  end

  // scan: pair (i, j) is read in one cycle and tallied in the next
  // candidate i has rank range [less, less+eq)
  always_comb begin
    state_d = state_q; wr_d = wr_q; n_d = n_q; i_d = i_q; j_d = j_q;
    less_d = less_q; eq_d = eq_q; lo_d = lo_q; hi_d = hi_q;
    got_lo_d = got_lo_q; got_hi_d = got_hi_q;
    rd_v_d = 1'b0;
    rd_last_d = (j_q == n_q - TapW'(1));
    unique case (state_q)
      S_COLLECT: begin
        if (ctrl_i.clear) wr_d = '0;
        if (ctrl_i.push) wr_d = wr_q + TapW'(1);
        if (ctrl_i.done) begin
          state_d = S_SCAN; n_d = ctrl_i.count; i_d = '0; j_d = '0;
          less_d = '0; eq_d = '0; got_lo_d = 1'b0; got_hi_d = 1'b0;
        end
      end
      S_SCAN: begin
        rd_v_d = 1'b1;
        j_d    = j_q + TapW'(1);
        if (j_q == n_q - TapW'(1)) begin
          j_d = '0;
          i_d = i_q + TapW'(1);
          if (i_q == n_q - TapW'(1)) state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        state_d = S_COLLECT; wr_d = '0;
      end
      default: state_d = S_COLLECT;
    endcase
    // tally of the pair read in the previous cycle
    if (rd_v_q) begin
      less_d = TapW'(less_n);
      eq_d   = TapW'(eq_n);
      if (rd_last_q) begin
        if (!got_lo_q && k_lo >= TapW'(less_n) &&
            {1'b0, k_lo} < less_n + eq_n) begin
          lo_d = cand_q; got_lo_d = 1'b1;
        end
        if (!got_hi_q && k_hi >= TapW'(less_n) &&
            {1'b0, k_hi} < less_n + eq_n) begin
          hi_d = cand_q; got_hi_d = 1'b1;
        end
        less_d = '0; eq_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_COLLECT; wr_q <= '0;
    end else begin
      state_q <= state_d; wr_q <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; i_q <= i_d; j_q <= j_d; less_q <= less_d; eq_q <= eq_d;
    lo_q <= lo_d; hi_q <= hi_d; got_lo_q <= got_lo_d; got_hi_q <= got_hi_d;
    rd_v_q <= rd_v_d; rd_last_q <= rd_last_d;
  end

  // odd count: both ranks equal, average equals the middle value
  assign valid_o  = (state_q == S_OUT);
  assign median_o = n_q[0] ? lo_q : avg[7:0];

  a_push_collect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> state_q == S_COLLECT) else $error("push outside collect");
  a_out_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("median held twice");
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> got_lo_q && got_hi_q) else $error("rank not found");
endmodule

// ===== rtl/edge_clipped_median_filter_core.sv =====
// top level: pixel memory, window sequencer and three rank selectors
//
// A load is written on its accept edge and busy stays low, so loads can follow back to back.
// A query inside the image with a clipped window of n pixels (n up to 49) keeps busy
// high from its accept edge until the result shows, in the last busy cycle. In order:
// one memory read per window pixel gathers the window, a drain state follows, each
// channel's rank selector compares every pair of window samples, the last compare is
// tallied and the result shows. The next item can be accepted once busy falls.
// A query outside the image keeps busy high for one cycle and returns zeros in it.
// A result shows for one cycle on valid_o and the receiver cannot stall it.
// The pixel memory has no reset and no clearing pass: query only loaded pixels.
module edge_clipped_median_filter_core
  import ecmf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        op_i,
  input  logic [7:0]  col_i,
  input  logic [7:0]  row_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  output logic        valid_o,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic        position_ok_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_WAIT  = 5'b01000,
    S_RESP  = 5'b10000
  } ctl_state_e;

  ctl_state_e state_q, state_d;
  logic [2:0] wsize_q;
  logic [8:0] width_q, height_q;
  logic [8:0] w_eff, h_eff;
  logic [ColW-1:0] x0_q, x1_q, cx_q;
  logic [RowW-1:0] y1_q, cy_q;
  logic [TapW-1:0] cnt_q;
  logic       rd_pend_q;
  logic       ok_q;
  logic       accept, in_img;
  logic [9:0] xs, ys, xe, ye;
  logic [1:0] rad;
  pixel_t     mem [MaxWidth*MaxHeight];
  pixel_t     rd_q;
  logic       rd_en;
  sel_ctrl_t  ctrl;
  logic [2:0] sel_valid;
  logic [7:0] med_r, med_g, med_b;

  assign w_eff  = (width_q  > 9'(MaxWidth))  ? 9'(MaxWidth)  : width_q;
  assign h_eff  = (height_q > 9'(MaxHeight)) ? 9'(MaxHeight) : height_q;
  assign in_img = ({1'b0, col_i} < w_eff) && ({1'b0, row_i} < h_eff);
  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign rad = (wsize_q[2:1] > 2'(MaxRadius)) ? 2'(MaxRadius) : wsize_q[2:1];

  // clipped window bounds
  assign xs = ({2'b0, col_i} < {8'b0, rad}) ? '0 : {2'b0, col_i} - {8'b0, rad};
  assign ys = ({2'b0, row_i} < {8'b0, rad}) ? '0 : {2'b0, row_i} - {8'b0, rad};
  assign xe = ({2'b0, col_i} + {8'b0, rad} > {1'b0, w_eff} - 10'd1) ?
              {1'b0, w_eff} - 10'd1 : {2'b0, col_i} + {8'b0, rad};
  assign ye = ({2'b0, row_i} + {8'b0, rad} > {1'b0, h_eff} - 10'd1) ?
              {1'b0, h_eff} - 10'd1 : {2'b0, row_i} + {8'b0, rad};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q <= 3'd3; width_q <= 9'd256; height_q <= 9'd256;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegWindowSize:  wsize_q  <= cfg_data_i[2:0];
        RegImageWidth:  width_q  <= cfg_data_i;
        RegImageHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pixel memory
  assign rd_en = (state_q == S_READ);
  always_ff @(posedge clk_i) begin
    if (accept && op_i == OpLoad && in_img) begin
      mem[{row_i, col_i}] <= {red_in_i, green_in_i, blue_in_i};
    end
    if (rd_en) rd_q <= mem[{cy_q, cx_q}];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = (op_i == OpFilter && in_img) ? S_READ :
                                     (op_i == OpFilter) ? S_RESP : S_IDLE;
      S_READ:  if (cx_q == x1_q && cy_q == y1_q) state_d = S_DRAIN;
      S_DRAIN: state_d = S_WAIT;
      S_WAIT:  if (sel_valid[0]) state_d = S_IDLE;
      S_RESP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; rd_pend_q <= 1'b0; cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_en;
      if (accept) cnt_q <= '0;
      else if (rd_en) cnt_q <= cnt_q + TapW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x0_q <= xs[ColW-1:0]; x1_q <= xe[ColW-1:0];
      y1_q <= ye[RowW-1:0];
      cx_q <= xs[ColW-1:0]; cy_q <= ys[RowW-1:0];
      ok_q <= in_img;
    end else if (rd_en) begin
      if (cx_q == x1_q) begin
        cx_q <= x0_q; cy_q <= cy_q + RowW'(1);
      end else begin
        cx_q <= cx_q + ColW'(1);
      end
    end
  end

  assign ctrl.clear = accept;
  assign ctrl.push  = rd_pend_q;
  assign ctrl.done  = (state_q == S_DRAIN);
  assign ctrl.count = cnt_q;

  ecmf_rank_sel u_sel_r (.clk_i, .rst_ni, .ctrl_i(ctrl), .sample_i(rd_q[23:16]),
                         .valid_o(sel_valid[2]), .median_o(med_r));
  ecmf_rank_sel u_sel_g (.clk_i, .rst_ni, .ctrl_i(ctrl), .sample_i(rd_q[15:8]),
                         .valid_o(sel_valid[1]), .median_o(med_g));
  ecmf_rank_sel u_sel_b (.clk_i, .rst_ni, .ctrl_i(ctrl), .sample_i(rd_q[7:0]),
                         .valid_o(sel_valid[0]), .median_o(med_b));

  // result beat
  assign valid_o       = (state_q == S_RESP) || (state_q == S_WAIT && sel_valid[0]);
  assign position_ok_o = (state_q == S_WAIT) && ok_q;
  assign red_out_o     = (state_q == S_WAIT) ? med_r : 8'd0;
  assign green_out_o   = (state_q == S_WAIT) ? med_g : 8'd0;
  assign blue_out_o    = (state_q == S_WAIT) ? med_b : 8'd0;

  a_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_valid[0] |-> sel_valid[1] && sel_valid[2]) else $error("lanes out of step");
  a_read_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !rd_en) else $error("accept during window read");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.done |-> cnt_q != '0) else $error("empty window");
endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the edge-clipped median filter core
`timescale 1ns / 100ps

module testbench
  import ecmf_pkg::*;
;

  localparam logic [1:0] RegSpare = 2'd3;
  localparam int unsigned TargetItems = 1550;
  localparam longint unsigned CycleLimit = 15_000_000;

  typedef struct {
    logic       op;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    bit         hold;
  } pix_cmd_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       ok;
  } filt_res_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       op_i = OpLoad;
  logic [7:0] col_i = '0;
  logic [7:0] row_i = '0;
  logic [7:0] red_in_i = '0;
  logic [7:0] green_in_i = '0;
  logic [7:0] blue_in_i = '0;
  logic       valid_o;
  logic [7:0] red_out_o;
  logic [7:0] green_out_o;
  logic [7:0] blue_out_o;
  logic       position_ok_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [8:0] cfg_data_i = '0;

  // pending commands, expected filter answers, shadow image and settings
  pix_cmd_t  cmd_q[$];
  filt_res_t median_q[$];
  pix_cmd_t  cur_cmd;
  logic [23:0] image_mem [0:65535];
  bit          filled [0:65535];
  int unsigned win_size = 3;
  int unsigned img_w = 256;
  int unsigned img_h = 256;
  int unsigned accepted = 0;
  int unsigned pushed = 0;
  int unsigned fails = 0;
  longint unsigned cycles = 0;

  edge_clipped_median_filter_core dut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned eff_dim(int unsigned v, int unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic bit in_image(int unsigned c, int unsigned r);
    return (c < eff_dim(img_w, MaxWidth)) && (r < eff_dim(img_h, MaxHeight));
  endfunction

  // clipped window corners for the current settings
  function automatic void clip_window(input int c, input int r,
                                      output int x0, output int x1,
                                      output int y0, output int y1);
    int rad;
    rad = win_size / 2;
    if (rad > MaxRadius) rad = MaxRadius;
    x0 = (c - rad < 0) ? 0 : c - rad;
    y0 = (r - rad < 0) ? 0 : r - rad;
    x1 = c + rad;
    y1 = r + rad;
    if (x1 > int'(eff_dim(img_w, MaxWidth)) - 1) x1 = int'(eff_dim(img_w, MaxWidth)) - 1;
    if (y1 > int'(eff_dim(img_h, MaxHeight)) - 1) y1 = int'(eff_dim(img_h, MaxHeight)) - 1;
  endfunction

  // middle value, or floor of the mean of the two middle values
  function automatic logic [7:0] middle_of(int v[$]);
    int n;
    int t;
    int j;
    n = v.size();
    for (int i = 1; i < n; i++) begin
      t = v[i];
      j = i - 1;
      while (j >= 0 && v[j] > t) begin
        v[j+1] = v[j];
        j--;
      end
      v[j+1] = t;
    end
    if (n % 2 == 1) return 8'(v[(n-1)/2]);
    return 8'((v[n/2] + v[n/2-1]) / 2);
  endfunction

  function automatic filt_res_t median_at(int c, int r);
    filt_res_t res;
    int x0, x1, y0, y1;
    int rv[$], gv[$], bv[$];
    logic [23:0] p;
    res = '{red: 8'd0, green: 8'd0, blue: 8'd0, ok: 1'b0};
    if (!in_image(c, r)) return res;
    clip_window(c, r, x0, x1, y0, y1);
    for (int x = x0; x <= x1; x++)
      for (int y = y0; y <= y1; y++) begin
        p = image_mem[y*MaxWidth + x];
        rv.push_back(p[23:16]);
        gv.push_back(p[15:8]);
        bv.push_back(p[7:0]);
      end
    res.red = middle_of(rv);
    res.green = middle_of(gv);
    res.blue = middle_of(bv);
    res.ok = 1'b1;
    return res;
  endfunction

  function automatic logic [7:0] rnd_chan();
    int k;
    k = $urandom_range(0, 3);
    if (k == 0) return 8'd0;
    if (k == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int unsigned idle_pct();
    if (accepted < TargetItems / 3) return 25;
    if (accepted < 2 * TargetItems / 3) return 52;
    return 0;
  endfunction

  task automatic push_load(int c, int r, logic [7:0] rd, logic [7:0] gr, logic [7:0] bl);
    cmd_q.push_back('{op: OpLoad, col: 8'(c), row: 8'(r), red: rd, green: gr, blue: bl,
                      hold: 0});
    if (in_image(c, r)) filled[r*MaxWidth + c] = 1'b1;
    pushed++;
  endtask

  // loads any unwritten pixel of the window first, then asks for the median
  task automatic push_query(int c, int r, bit hold);
    int x0, x1, y0, y1;
    if (in_image(c, r)) begin
      clip_window(c, r, x0, x1, y0, y1);
      for (int y = y0; y <= y1; y++)
        for (int x = x0; x <= x1; x++)
          if (!filled[y*MaxWidth + x]) push_load(x, y, rnd_chan(), rnd_chan(), rnd_chan());
    end
    cmd_q.push_back('{op: OpFilter, col: 8'(c), row: 8'(r),
                      red: 8'($urandom_range(0, 255)),
                      green: 8'($urandom_range(0, 255)),
                      blue: 8'($urandom_range(0, 255)),
                      hold: hold});
    pushed++;
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [8:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegWindowSize:  win_size = val[2:0];
      RegImageWidth:  img_w = val;
      RegImageHeight: img_h = val;
      default: ;
    endcase
  endtask

  // block idle: nothing pending, nothing expected, last load retired
  task automatic wait_idle();
    do @(posedge clk_i); while (cmd_q.size() != 0 || start || median_q.size() != 0);
    repeat (8) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic set_geometry(int unsigned ws, int unsigned w, int unsigned h);
    wait_idle();
    cfg_write(RegWindowSize, 9'(ws));
    cfg_write(RegImageWidth, 9'(w));
    cfg_write(RegImageHeight, 9'(h));
  endtask

  function automatic int unsigned pick_dim();
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) return $urandom_range(1, 16);
    if (k < 80) return 256;
    if (k < 85) return 0;
    if (k < 90) return 511;
    return $urandom_range(17, 300);
  endfunction

  // random phase: mostly filled-window queries, some noise
  task automatic random_phase(int unsigned n);
    int unsigned stop;
    int k;
    int unsigned w, h;
    stop = pushed + n;
    w = eff_dim(img_w, MaxWidth);
    h = eff_dim(img_h, MaxHeight);
    push_query(0, 0, 1'b1);
    while (pushed < stop) begin
      k = $urandom_range(0, 99);
      if (k < 10 || w == 0 || h == 0)
        push_load($urandom_range(0, 255), $urandom_range(0, 255),
                  rnd_chan(), rnd_chan(), rnd_chan());
      else if (k < 20)
        push_query($urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
      else if (k < 30)
        push_load($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                  rnd_chan(), rnd_chan(), rnd_chan());
      else
        push_query($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                   $urandom_range(0, 49) == 0);
    end
  endtask

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // driver: beat accepted on start and not busy
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        accepted++;
        if (cur_cmd.op == OpLoad) begin
          if (in_image(cur_cmd.col, cur_cmd.row))
            image_mem[cur_cmd.row*MaxWidth + cur_cmd.col] =
              {cur_cmd.red, cur_cmd.green, cur_cmd.blue};
        end else begin
          median_q.push_back(median_at(cur_cmd.col, cur_cmd.row));
        end
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (cmd_q.size() > 0 && !(cmd_q[0].hold && median_q.size() > 0) &&
                   $urandom_range(0, 99) >= idle_pct()) begin
        cur_cmd = cmd_q.pop_front();
        start <= 1'b1;
        op_i <= cur_cmd.op;
        col_i <= cur_cmd.col;
        row_i <= cur_cmd.row;
        red_in_i <= cur_cmd.red;
        green_in_i <= cur_cmd.green;
        blue_in_i <= cur_cmd.blue;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compare each result beat with the oldest expected median
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (median_q.size() == 0) begin
        $error("unexpected result beat");
        fails++;
      end else begin
        if (red_out_o !== median_q[0].red) begin
          $error("red_out: expected %0d, got %0d", median_q[0].red, red_out_o);
          fails++;
        end
        if (green_out_o !== median_q[0].green) begin
          $error("green_out: expected %0d, got %0d", median_q[0].green, green_out_o);
          fails++;
        end
        if (blue_out_o !== median_q[0].blue) begin
          $error("blue_out: expected %0d, got %0d", median_q[0].blue, blue_out_o);
          fails++;
        end
        if (position_ok_o !== median_q[0].ok) begin
          $error("position_ok: expected %0d, got %0d", median_q[0].ok, position_ok_o);
          fails++;
        end
        void'(median_q.pop_front());
      end
    end
  end

  // reset
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // stimulus
  initial begin
    for (int i = 0; i < 65536; i++) begin
      image_mem[i] = '0;
      filled[i] = 1'b0;
    end
    @(posedge rst_ni);
    // reset geometry: corners give even clipped windows
    push_load(5, 5, 8'd255, 8'd255, 8'd255);
    push_load(5, 5, 8'd0, 8'd0, 8'd0);
    push_query(0, 0, 1'b0);
    push_query(255, 255, 1'b0);
    push_query(255, 0, 1'b0);
    push_query(0, 255, 1'b0);
    push_query(5, 5, 1'b1);
    // tiny image, single pixel window, outside loads and queries
    set_geometry(0, 4, 3);
    push_load(4, 0, 8'd1, 8'd2, 8'd3);
    push_load(0, 3, 8'd1, 8'd2, 8'd3);
    push_query(9, 9, 1'b0);
    push_query(3, 2, 1'b0);
    wait_idle();
    cfg_write(RegWindowSize, 9'd7);
    cfg_write(RegSpare, 9'h1ff);
    push_query(1, 1, 1'b0);
    push_query(3, 0, 1'b0);
    // zero and oversized dimensions
    set_geometry(2, 0, 5);
    push_load(0, 0, 8'd9, 8'd9, 8'd9);
    push_query(0, 0, 1'b0);
    set_geometry(6, 511, 300);
    push_query(255, 255, 1'b0);
    push_query(0, 128, 1'b0);
    // random phases
    while (pushed < TargetItems) begin
      set_geometry(($urandom_range(0, 99) < 80) ? $urandom_range(0, 4)
                                                : $urandom_range(5, 7),
                   pick_dim(), pick_dim());
      if ($urandom_range(0, 3) == 0) cfg_write(RegSpare, 9'($urandom_range(0, 511)));
      random_phase(120);
    end
    wait_idle();
    repeat (50) @(posedge clk_i);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ecmf_pkg.sv
rtl/ecmf_rank_sel.sv
rtl/edge_clipped_median_filter_core.sv
sim/testbench.sv
